// File: design/fbfl_pkg.sv
package fbfl_pkg;

  // Default number of blocks in the pool
  localparam int unsigned POOL_ENTRIES_DEF = 256;

  // Fixed field widths
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned RID_W    = 9;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned STATUS_W = 3;

  localparam logic [LEN_W-1:0] BLOCK_SIZE_RST = 16'd4096;

  // Request codes
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_RING_FULL = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // latch the item and read the head slot
    logic exec;   // evaluate, update the ring, register the result
  } cmd_t;

endpackage

// File: design/fbfl_ram.sv
module fbfl_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/fbfl_ctrl.sv
module fbfl_ctrl import fbfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// File: design/fbfl_dp.sv
module fbfl_dp import fbfl_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                action_i,
  input  logic [LEN_W-1:0]    key_length_i,
  input  logic [LEN_W-1:0]    value_length_i,
  input  logic [SEQ_W-1:0]    sequence_number_i,
  input  logic                anchor_in_i,
  input  logic [RID_W-1:0]    release_id_i,
  input  logic                cfg_we_i,
  input  logic [LEN_W-1:0]    cfg_data_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_id_o,
  output logic [LEN_W-1:0]    key_size_o,
  output logic [LEN_W-1:0]    value_size_o,
  output logic [SEQ_W-1:0]    seq_out_o,
  output logic                anchor_out_o
);

  localparam int unsigned IdW  = $clog2(POOL_ENTRIES);
  localparam int unsigned CntW = $clog2(POOL_ENTRIES + 1);
  localparam logic [IdW-1:0]  LastSlot = IdW'(POOL_ENTRIES - 1);
  localparam logic [CntW-1:0] FillMax  = CntW'(POOL_ENTRIES);

  function automatic logic [IdW-1:0] next_slot(input logic [IdW-1:0] p);
    logic [IdW-1:0] n;
    if (p == LastSlot) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  // Request registers
  logic             action_q;
  logic [LEN_W-1:0] klen_q, vlen_q;
  logic [SEQ_W-1:0] seq_q;
  logic             anchor_q;
  logic [RID_W-1:0] rid_q;

  logic [LEN_W-1:0] block_size_q;
  logic [IdW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             done_q;
  status_e          status_q, status_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;

  // Ring memory: {valid, id}
  logic           ram_we;
  logic [IdW-1:0] ram_waddr;
  logic [IdW:0]   ram_wdata, ram_rdata;

  fbfl_ram #(
    .WIDTH (IdW + 1),
    .DEPTH (POOL_ENTRIES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      klen_q   <= key_length_i;
      vlen_q   <= value_length_i;
      seq_q    <= sequence_number_i;
      anchor_q <= anchor_in_i;
      rid_q    <= release_id_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      handle_q <= handle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RST;
      head_q       <= '0;
      tail_q       <= LastSlot;
      fill_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        block_size_q <= cfg_data_i;
      end
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      done_q <= cmd_i.exec;
    end
  end

  logic [LEN_W:0] len_sum;
  logic           too_large, slot_written, slot_valid, bad_id, ring_full;
  logic [IdW-1:0] slot_id, tail_next;

  always_comb begin
    len_sum      = {1'b0, klen_q} + {1'b0, vlen_q};
    too_large    = len_sum >= {1'b0, block_size_q};
    // Slots at or beyond the fill mark have never been written; their contents are ignored
    slot_written = CntW'(head_q) < fill_q;
    slot_valid   = slot_written ? ram_rdata[IdW] : 1'b1;
    slot_id      = slot_written ? ram_rdata[IdW-1:0] : head_q;
    bad_id       = 32'(rid_q) >= 32'(POOL_ENTRIES);
    ring_full    = tail_q == head_q;
    tail_next    = next_slot(tail_q);

    head_d    = head_q;
    tail_d    = tail_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = '0;
    status_d  = ST_OK;
    handle_d  = '0;

    if (action_q == ACT_ALLOC) begin
      if (too_large) begin
        status_d = ST_TOO_LARGE;
      end else if (!slot_valid) begin
        status_d = ST_NO_FREE;
      end else begin
        handle_d  = HANDLE_W'(slot_id);
        ram_we    = cmd_i.exec;
        ram_waddr = head_q;
        ram_wdata = {1'b0, slot_id};
        if (cmd_i.exec) begin
          head_d = next_slot(head_q);
        end
      end
    end else begin
      if (bad_id) begin
        status_d = ST_BAD_ID;
      end else if (ring_full) begin
        status_d = ST_RING_FULL;
      end else begin
        ram_we    = cmd_i.exec;
        ram_waddr = tail_next;
        ram_wdata = {1'b1, IdW'(rid_q)};
        if (cmd_i.exec) begin
          tail_d = tail_next;
        end
      end
    end

    // Writes land in order from slot 0, so the written slots form a prefix
    fill_d = fill_q;
    if (ram_we && (CntW'(ram_waddr) == fill_q) && (fill_q != FillMax)) begin
      fill_d = fill_q + 1'b1;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign handle_id_o  = handle_q;
  assign key_size_o   = klen_q;
  assign value_size_o = vlen_q;
  assign seq_out_o    = seq_q;
  assign anchor_out_o = anchor_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill mark beyond pool size");

  a_alloc_moves_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && action_q == ACT_ALLOC && status_q == ST_OK)
      |-> head_q != $past(head_q))
    else $error("successful allocate left head in place");

  a_fail_keeps_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != ST_OK)
      |-> (head_q == $past(head_q) && tail_q == $past(tail_q)))
    else $error("failed request moved a ring pointer");

endmodule

// File: design/fixed_block_free_list_allocator.sv
// Fixed-size block allocator over a ring of free block IDs. Raise start with
// a request while busy is low; the request is taken at that edge. busy is
// then high while the head slot of the ring memory, read at the accept
// edge, is checked and the ring is updated; in the cycle after that, done_o
// is high for exactly one cycle with the status, the handle and the echoed
// metadata. The receiver cannot stall: take the result in that cycle or
// lose it. A new request may be accepted in the same cycle that a result is
// shown, but not while busy is high, as the registered read of the single
// ring memory is followed by its write.
// No clearing pass is run after reset: a fill mark tracks which slots have
// been written, and unwritten slots read as free holding their own index.
// block_size is written through the cfg channel, which is always ready;
// write it only while no request is in flight.
module fixed_block_free_list_allocator import fbfl_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request command
  input  logic                start,
  output logic                busy,
  input  logic                action_i,
  input  logic [LEN_W-1:0]    key_length_i,
  input  logic [LEN_W-1:0]    value_length_i,
  input  logic [SEQ_W-1:0]    sequence_number_i,
  input  logic                anchor_in_i,
  input  logic [RID_W-1:0]    release_id_i,
  // result strobe
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_id_o,
  output logic [LEN_W-1:0]    key_size_o,
  output logic [LEN_W-1:0]    value_size_o,
  output logic [SEQ_W-1:0]    seq_out_o,
  output logic                anchor_out_o,
  // block_size write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LEN_W-1:0]    cfg_data_i
);

  cmd_t cmd;

  // Accept a register write in any cycle
  assign cfg_ready_o = 1'b1;

  fbfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  fbfl_dp #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .action_i          (action_i),
    .key_length_i      (key_length_i),
    .value_length_i    (value_length_i),
    .sequence_number_i (sequence_number_i),
    .anchor_in_i       (anchor_in_i),
    .release_id_i      (release_id_i),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .handle_id_o       (handle_id_o),
    .key_size_o        (key_size_o),
    .value_size_o      (value_size_o),
    .seq_out_o         (seq_out_o),
    .anchor_out_o      (anchor_out_o)
  );

  // Each accepted item is evaluated and then gives a single result
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item not evaluated");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("evaluation not followed by a single result");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without an evaluated item");

endmodule
